// ----- hdl/unicode_byte_error_scanner_core_defines.svh -----
// Assertion macros shared by the scanner modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef UNICODE_BYTE_ERROR_SCANNER_CORE_DEFINES_SVH
`define UNICODE_BYTE_ERROR_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, masked during reset
`define UBES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define UBES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ubes_pkg.sv -----
// Types and constants of the byte error scanner.
// No dependencies; used by every module of the block.
package ubes_pkg;

    localparam int unsigned MAX_RES     = 5;
    localparam int unsigned MAX_ERR     = 4;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [1:0] MODE_UTF8  = 2'd0;
    localparam logic [1:0] MODE_UTF16 = 2'd1;
    localparam logic [1:0] MODE_UTF32 = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_ENDIAN = 2'd1;

    localparam logic [3:0] KIND_BAD_CONT    = 4'd0;
    localparam logic [3:0] KIND_TRUNC       = 4'd1;
    localparam logic [3:0] KIND_INVALID     = 4'd2;
    localparam logic [3:0] KIND_ODD         = 4'd3;
    localparam logic [3:0] KIND_BAD_HIGH    = 4'd4;
    localparam logic [3:0] KIND_BAD_LOW     = 4'd5;
    localparam logic [3:0] KIND_MISSING_LOW = 4'd6;
    localparam logic [3:0] KIND_LENGTH      = 4'd7;
    localparam logic [3:0] KIND_ABOVE_MAX   = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic        is_error;
        logic [3:0]  error_kind;
        logic [31:0] bad_value;
        logic [31:0] first_position;
        logic [2:0]  position_count;
        logic [31:0] error_total;
        logic        last_of_run;
    } t_out;

    // all results caused by one byte
    typedef struct packed {
        logic [2:0]              num;
        t_out [MAX_RES-1:0]      rec;
    } t_bundle;

endpackage

// ----- hdl/ubes_front.sv -----
// Front end: stream state, byte classification, builds the result bundle per byte.
// Depends on ubes_pkg.
module ubes_front #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_acc,
    input  ubes_pkg::t_in      i_in,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [1:0]         i_cfg_data,
    output logic               o_q_push,
    output ubes_pkg::t_bundle  o_q_data
);

    localparam int unsigned PW = POSITION_WIDTH;

    typedef struct packed {
        logic [2:0]                      num;
        ubes_pkg::t_out [ubes_pkg::MAX_ERR-1:0] rec;
    } t_elist;

    logic [1:0]    r_mode;
    logic          r_be;
    logic [PW-1:0] r_index;
    logic [7:0]    r_held [3];
    logic [1:0]    r_hcnt;
    logic [1:0]    r_need;
    logic [PW-1:0] r_seq;
    logic [31:0]   r_errs;
    logic          r_wrapped;

    logic [7:0]    n_held [3];
    logic [1:0]    n_hcnt;
    logic [1:0]    n_need;
    logic [PW-1:0] n_seq;
    logic [31:0]   n_errs;
    logic [PW-1:0] n_index;
    logic          n_wrapped;

    function automatic t_elist add_err(t_elist l, logic [3:0] kind, logic [31:0] val,
                                       logic [PW-1:0] pos, logic [2:0] cnt);
        t_elist r;
        r = l;
        if (l.num < 3'(ubes_pkg::MAX_ERR)) begin
            r.rec[l.num[1:0]] = '{is_error: 1'b1, error_kind: kind, bad_value: val,
                                  first_position: 32'(pos), position_count: cnt,
                                  error_total: 32'd0, last_of_run: 1'b0};
            r.num = l.num + 3'd1;
        end
        return r;
    endfunction

    // 0 ASCII, 1..3 continuation bytes needed, 4 invalid lead
    function automatic logic [2:0] u8_class(logic [7:0] b);
        if (b[7] == 1'b0)           return 3'd0;
        else if (b[7:5] == 3'b110)  return 3'd1;
        else if (b[7:4] == 4'b1110) return 3'd2;
        else if (b[7:3] == 5'b11110) return 3'd3;
        else                        return 3'd4;
    endfunction

    function automatic logic [15:0] unit16(logic [7:0] a, logic [7:0] b, logic be);
        return be ? {a, b} : {b, a};
    endfunction

    function automatic logic surrogate(logic [15:0] u);
        return (u >= 16'hd800) && (u <= 16'hdfff);
    endfunction

    always_comb begin
        logic [7:0]    tmp [4];
        logic [2:0]    n;
        logic [PW-1:0] x;
        logic [PW-1:0] start;
        t_elist        el;
        logic          do_hold;
        logic          clr;
        logic          bom;
        logic          done;
        logic [2:0]    i;
        logic [2:0]    c;
        logic [2:0]    idx;
        logic [7:0]    bb;
        logic [15:0]   u;
        logic [15:0]   lo;
        logic [31:0]   w;
        logic [32:0]   tot;
        logic [2:0]    cnt;
        logic [7:0]    b;

        b = i_in.data_byte;
        for (int k = 0; k < 4; k++) tmp[k] = 8'd0;
        for (int k = 0; k < 3; k++) tmp[k] = r_held[k];
        n       = {1'b0, r_hcnt};
        x       = r_index;
        start   = (r_hcnt != 2'd0) ? r_seq : x;
        el      = '0;
        do_hold = 1'b0;
        clr     = 1'b0;
        bom     = 1'b0;
        done    = 1'b0;
        i       = 3'd0;
        c       = 3'd0;
        idx     = 3'd0;
        bb      = 8'd0;
        u       = 16'd0;
        lo      = 16'd0;
        w       = 32'd0;
        n_need  = r_need;

        case (r_mode)
            ubes_pkg::MODE_UTF8: begin
                tmp[n[1:0]] = b;
                n = n + 3'd1;
                if (i_in.stream_end) begin
                    for (int s = 0; s < 4; s++) begin
                        if (i < n) begin
                            bb = tmp[i[1:0]];
                            c  = u8_class(bb);
                            if (c == 3'd0) begin
                                i = i + 3'd1;
                            end else if (c == 3'd4) begin
                                el = add_err(el, ubes_pkg::KIND_INVALID, 32'(bb),
                                             start + PW'(i), 3'd1);
                                i = i + 3'd1;
                            end else if ((i + c) < n) begin
                                for (int k = 1; k <= 3; k++) begin
                                    if (3'(k) <= c) begin
                                        idx = i + 3'(k);
                                        if (tmp[idx[1:0]][7:6] != 2'b10) begin
                                            el = add_err(el, ubes_pkg::KIND_BAD_CONT,
                                                         32'(tmp[idx[1:0]]),
                                                         start + PW'(idx), 3'd1);
                                        end
                                    end
                                end
                                i = i + c + 3'd1;
                            end else begin
                                el = add_err(el, ubes_pkg::KIND_TRUNC, 32'(bb),
                                             start + PW'(i), 3'd1);
                                i = i + 3'd1;
                            end
                        end
                    end
                end else if (r_hcnt == 2'd0) begin
                    c = u8_class(b);
                    if (c == 3'd4) begin
                        el = add_err(el, ubes_pkg::KIND_INVALID, 32'(b), x, 3'd1);
                    end else if (c != 3'd0) begin
                        do_hold = 1'b1;
                        n_need  = c[1:0];
                    end
                end else if (n == ({1'b0, r_need} + 3'd1)) begin
                    for (int k = 1; k <= 3; k++) begin
                        if (2'(k) <= r_need && tmp[k][7:6] != 2'b10) begin
                            el = add_err(el, ubes_pkg::KIND_BAD_CONT, 32'(tmp[k]),
                                         r_seq + PW'(k), 3'd1);
                        end
                    end
                    clr = 1'b1;
                end else begin
                    do_hold = 1'b1;
                end
            end
            ubes_pkg::MODE_UTF16: begin
                bom = !r_wrapped && (x < PW'(2));
                if (!bom) begin
                    tmp[n[1:0]] = b;
                    n = n + 3'd1;
                end
                if (i_in.stream_end) begin
                    for (int s = 0; s < 3; s++) begin
                        if (!done && i < n) begin
                            if ((i + 3'd1) >= n) begin
                                el = add_err(el, ubes_pkg::KIND_ODD, 32'(tmp[i[1:0]]),
                                             start + PW'(i), 3'd1);
                                done = 1'b1;
                            end else begin
                                idx = i + 3'd1;
                                u = unit16(tmp[i[1:0]], tmp[idx[1:0]], r_be);
                                if (surrogate(u)) begin
                                    if ((i + 3'd3) < n) begin
                                        lo = unit16(tmp[2], tmp[3], r_be);
                                        if (!(u >= 16'hd800 && u <= 16'hdbff))
                                            el = add_err(el, ubes_pkg::KIND_BAD_HIGH,
                                                         32'(u), start, 3'd2);
                                        if (!(lo >= 16'hdc00 && lo <= 16'hdfff))
                                            el = add_err(el, ubes_pkg::KIND_BAD_LOW,
                                                         32'(lo), start + PW'(2), 3'd2);
                                        i = i + 3'd4;
                                    end else begin
                                        el = add_err(el, ubes_pkg::KIND_MISSING_LOW,
                                                     32'(u), start + PW'(i), 3'd2);
                                        i = i + 3'd2;
                                    end
                                end else begin
                                    i = i + 3'd2;
                                end
                            end
                        end
                    end
                end else if (!bom) begin
                    if (n == 3'd2) begin
                        if (surrogate(unit16(tmp[0], tmp[1], r_be))) do_hold = 1'b1;
                        else clr = 1'b1;
                    end else if (n == 3'd4) begin
                        u  = unit16(tmp[0], tmp[1], r_be);
                        lo = unit16(tmp[2], tmp[3], r_be);
                        if (!(u >= 16'hd800 && u <= 16'hdbff))
                            el = add_err(el, ubes_pkg::KIND_BAD_HIGH, 32'(u), r_seq, 3'd2);
                        if (!(lo >= 16'hdc00 && lo <= 16'hdfff))
                            el = add_err(el, ubes_pkg::KIND_BAD_LOW, 32'(lo),
                                         r_seq + PW'(2), 3'd2);
                        clr = 1'b1;
                    end else begin
                        do_hold = 1'b1;
                    end
                end
            end
            ubes_pkg::MODE_UTF32: begin
                bom = !r_wrapped && (x < PW'(4));
                if (!bom) begin
                    tmp[n[1:0]] = b;
                    n = n + 3'd1;
                end
                if (n == 3'd4) begin
                    w = r_be ? {tmp[0], tmp[1], tmp[2], tmp[3]}
                             : {tmp[3], tmp[2], tmp[1], tmp[0]};
                    if (w > 32'h0010ffff)
                        el = add_err(el, ubes_pkg::KIND_ABOVE_MAX, w, start, 3'd4);
                    clr = 1'b1;
                end else if (!bom && !i_in.stream_end) begin
                    do_hold = 1'b1;
                end
                // length check is the last error of the stream
                if (i_in.stream_end && ((x[1:0] + 2'd1) != 2'd0))
                    el = add_err(el, ubes_pkg::KIND_LENGTH, 32'(b), x, 3'd1);
            end
            default: begin
            end
        endcase

        for (int k = 0; k < 3; k++) n_held[k] = r_held[k];
        n_hcnt = r_hcnt;
        n_seq  = r_seq;
        if (clr) begin
            n_hcnt = 2'd0;
        end else if (do_hold) begin
            if (r_hcnt == 2'd0) n_seq = x;
            if (r_hcnt != 2'd3) begin
                n_held[r_hcnt] = b;
                n_hcnt = r_hcnt + 2'd1;
            end
        end

        tot    = {1'b0, r_errs} + 33'(el.num);
        n_errs = tot[32] ? 32'hffff_ffff : tot[31:0];

        n_index   = x + PW'(1);
        n_wrapped = r_wrapped || (n_index == '0);

        o_q_data = '0;
        for (int k = 0; k < ubes_pkg::MAX_ERR; k++) o_q_data.rec[k] = el.rec[k];
        cnt = el.num;
        if (i_in.stream_end) begin
            o_q_data.rec[cnt] = '{is_error: 1'b0, error_kind: 4'd0, bad_value: 32'd0,
                                  first_position: 32'd0, position_count: 3'd0,
                                  error_total: n_errs, last_of_run: 1'b0};
            cnt = cnt + 3'd1;
        end
        o_q_data.num = cnt;
        if (cnt != 3'd0) o_q_data.rec[cnt - 3'd1].last_of_run = 1'b1;
        o_q_push = i_acc && (cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= ubes_pkg::MODE_UTF8;
            r_be      <= 1'b0;
            r_index   <= '0;
            r_hcnt    <= 2'd0;
            r_need    <= 2'd0;
            r_seq     <= '0;
            r_errs    <= 32'd0;
            r_wrapped <= 1'b0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ubes_pkg::REG_MODE)   r_mode <= i_cfg_data;
            if (i_cfg_index == ubes_pkg::REG_ENDIAN) r_be   <= i_cfg_data[0];
            if (i_cfg_index == ubes_pkg::REG_MODE || i_cfg_index == ubes_pkg::REG_ENDIAN) begin
                r_index   <= '0;
                r_hcnt    <= 2'd0;
                r_need    <= 2'd0;
                r_seq     <= '0;
                r_errs    <= 32'd0;
                r_wrapped <= 1'b0;
            end
        end else if (i_acc) begin
            if (i_in.stream_end) begin
                r_index   <= '0;
                r_hcnt    <= 2'd0;
                r_need    <= 2'd0;
                r_seq     <= '0;
                r_errs    <= 32'd0;
                r_wrapped <= 1'b0;
            end else begin
                r_index   <= n_index;
                r_hcnt    <= n_hcnt;
                r_need    <= n_need;
                r_seq     <= n_seq;
                r_errs    <= n_errs;
                r_wrapped <= n_wrapped;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            for (int k = 0; k < 3; k++) r_held[k] <= n_held[k];
        end
    end

endmodule

// ----- hdl/ubes_queue.sv -----
// Short bundle queue between front and back end.
// Depends on ubes_pkg and the assertion macro header.
`include "unicode_byte_error_scanner_core_defines.svh"
module ubes_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ubes_pkg::t_bundle i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ubes_pkg::t_bundle o_data
);

    localparam int unsigned AW = $clog2(ubes_pkg::QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(ubes_pkg::QUEUE_DEPTH + 1);

    ubes_pkg::t_bundle r_mem [ubes_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;
    logic              wr;
    logic              rd;

    assign o_full  = (r_cnt == CW'(ubes_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    function automatic logic [AW-1:0] nxt(logic [AW-1:0] p);
        return (p == AW'(ubes_pkg::QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= nxt(r_wp);
            if (rd) r_rp <= nxt(r_rp);
            r_cnt <= r_cnt + CW'(wr) - CW'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

    `UBES_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1,
        r_cnt <= CW'(ubes_pkg::QUEUE_DEPTH), "queue occupancy above depth")
    `UBES_ASSERT_IMP(a_q_noempty_bundle, i_clk, i_rst_n, o_valid,
        o_data.num != 3'd0, "empty bundle in queue")
    `UBES_ASSERT_NXT(a_q_push_seen, i_clk, i_rst_n, wr,
        o_valid, "written bundle not visible")

endmodule

// ----- hdl/ubes_back.sv -----
// Back end: walks each bundle and presents its records one per transaction.
// Depends on ubes_pkg and the assertion macro header.
`include "unicode_byte_error_scanner_core_defines.svh"
module ubes_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  ubes_pkg::t_bundle i_q_data,
    output logic              o_q_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output ubes_pkg::t_out    o_out
);

    logic              r_busy;
    ubes_pkg::t_bundle r_bundle;
    logic [2:0]        r_idx;
    logic              take;
    logic              last;

    assign take    = i_pop && r_busy;
    assign last    = (r_idx == (r_bundle.num - 3'd1));
    assign o_q_pop = i_q_valid && (!r_busy || (take && last));
    assign o_empty = !r_busy;
    assign o_out   = r_bundle.rec[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 3'd0;
        end else if (take) begin
            if (last) r_busy <= 1'b0;
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_bundle <= i_q_data;
    end

    `UBES_ASSERT_IMP(a_idx_range, i_clk, i_rst_n, r_busy,
        r_idx < r_bundle.num, "record index past bundle end")
    `UBES_ASSERT_NXT(a_drain, i_clk, i_rst_n, take && last && !i_q_valid,
        o_empty, "back end still busy after last record")
    `UBES_ASSERT_NXT(a_load, i_clk, i_rst_n, o_q_pop,
        !o_empty, "bundle taken but no record shown")

endmodule

// ----- hdl/unicode_byte_error_scanner_core.sv -----
// Top level of the Unicode byte error scanner (UTF-8/16/32 validation).
// Depends on ubes_pkg, ubes_front, ubes_queue, ubes_back and the macro header.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  input    | push / full          | i_in  (data_byte, stream_end)
//  result   | pop / empty          | o_out (error / summary record)
//  config   | i_cfg_valid / ready  | i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while full is low; the front end
// classifies it against the held bytes in that cycle and pushes all its
// results as one bundle. The back end hands out one record per cycle while
// pop is high, so a byte that causes k records holds the result side until
// all k are popped; the two-entry bundle queue absorbs the difference.
// Full rises only when that queue is full. The first record passes through
// the bundle queue and the back-end bundle register to the result ports.
// Reset is synchronous, active low; no clearing pass is needed.
// Config is always ready; mode and endian writes restart the stream state.
module unicode_byte_error_scanner_core #(
    parameter int unsigned POSITION_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  ubes_pkg::t_in  i_in,
    output logic           empty,
    input  logic           pop,
    output ubes_pkg::t_out o_out,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [1:0]     i_cfg_data
);

    logic              acc;
    logic              q_push;
    ubes_pkg::t_bundle q_in;
    logic              q_valid;
    logic              q_pop;
    ubes_pkg::t_bundle q_out;

    assign o_cfg_ready = 1'b1;
    // a byte is taken only when its bundle is sure to find room
    assign acc = push && !full;

    ubes_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    ubes_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    ubes_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_out),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the Unicode byte error scanner core.
// Depends on ubes_pkg and unicode_byte_error_scanner_core; models the scanner
// in a small class and compares every record handed out by the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Golden copy of the scanner: stream state, registers and the queue of
    // records still owed by the block.
    class scan_scoreboard;
        logic [1:0]      mode;
        logic            big_end;
        logic [31:0]     pos;
        logic [7:0]      held [3];
        int              n_held;
        int              n_needed;
        logic [31:0]     seq_start;
        logic [31:0]     err_cnt;
        bit              wrapped;
        ubes_pkg::t_out  owed [$];
        ubes_pkg::t_out  run [$];
        int              fails;

        function void clear_stream();
            pos = 0; n_held = 0; n_needed = 0; seq_start = 0;
            err_cnt = 0; wrapped = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [1:0] val);
            if (idx == ubes_pkg::REG_MODE) mode = val;
            else if (idx == ubes_pkg::REG_ENDIAN) big_end = val[0];
            else return;
            clear_stream();
        endfunction

        function void note_err(logic [3:0] kind, logic [31:0] val, logic [31:0] p,
                               logic [2:0] cnt);
            ubes_pkg::t_out r;
            if (run.size() >= ubes_pkg::MAX_RES - 1) return;
            r = '0;
            r.is_error = 1; r.error_kind = kind; r.bad_value = val;
            r.first_position = p; r.position_count = cnt;
            run = {run, r};
            if (err_cnt != 32'hffff_ffff) err_cnt++;
        endfunction

        function int lead_class(logic [7:0] b);
            if (b[7] == 0) return 0;
            if (b[7:5] == 3'b110) return 1;
            if (b[7:4] == 4'b1110) return 2;
            if (b[7:3] == 5'b11110) return 3;
            return 4;
        endfunction

        function void cont_check(logic [7:0] s [4], int base, int c, logic [31:0] p);
            for (int k = 1; k <= c; k++)
                if (s[base+k][7:6] != 2'b10)
                    note_err(ubes_pkg::KIND_BAD_CONT, s[base+k], p + k, 1);
        endfunction

        // stream end in UTF-8: leftovers rescanned as leads
        function void u8_tail(logic [7:0] s [4], int n, logic [31:0] p);
            int i, c;
            i = 0;
            while (i < n) begin
                c = lead_class(s[i]);
                if (c == 0) i++;
                else if (c == 4) begin
                    note_err(ubes_pkg::KIND_INVALID, s[i], p + i, 1); i++;
                end else if (i + c < n) begin
                    cont_check(s, i, c, p + i); i += c + 1;
                end else begin
                    note_err(ubes_pkg::KIND_TRUNC, s[i], p + i, 1); i++;
                end
            end
        endfunction

        function logic [15:0] u16(logic [7:0] s [4], int i);
            return big_end ? {s[i], s[i+1]} : {s[i+1], s[i]};
        endfunction

        function bit is_surr(logic [15:0] u);
            return u >= 16'hd800 && u <= 16'hdfff;
        endfunction

        function void pair_check(logic [7:0] s [4], int i, logic [31:0] p);
            logic [15:0] hi, lo;
            hi = u16(s, i); lo = u16(s, i + 2);
            if (!(hi >= 16'hd800 && hi <= 16'hdbff))
                note_err(ubes_pkg::KIND_BAD_HIGH, hi, p, 2);
            if (!(lo >= 16'hdc00 && lo <= 16'hdfff))
                note_err(ubes_pkg::KIND_BAD_LOW, lo, p + 2, 2);
        endfunction

        function void u16_tail(logic [7:0] s [4], int n, logic [31:0] p);
            int i;
            i = 0;
            while (i < n) begin
                if (i + 1 >= n) begin
                    note_err(ubes_pkg::KIND_ODD, s[i], p + i, 1);
                    break;
                end
                if (is_surr(u16(s, i))) begin
                    if (i + 3 < n) begin
                        pair_check(s, i, p + i); i += 4;
                    end else begin
                        note_err(ubes_pkg::KIND_MISSING_LOW, u16(s, i), p + i, 2); i += 2;
                    end
                end else i += 2;
            end
        endfunction

        function void hold(logic [7:0] b, logic [31:0] x);
            if (n_held == 0) seq_start = x;
            if (n_held < 3) begin
                held[n_held] = b; n_held++;
            end
        endfunction

        // accepted input transaction: work out its records
        function void note_input(ubes_pkg::t_in it);
            logic [7:0]      b, s [4];
            logic [31:0]     x, start, w;
            logic            fin, bom;
            int              n, c, n_old;
            ubes_pkg::t_out  r;
            b = it.data_byte; fin = it.stream_end; x = pos;
            n_old = n_held; n = n_held;
            start = n_held ? seq_start : x;
            run.delete();
            for (int k = 0; k < 4; k++) s[k] = (k < n_held) ? held[k] : 8'h00;
            if (mode == ubes_pkg::MODE_UTF8) begin
                s[n] = b; n++;
                if (fin) u8_tail(s, n, start);
                else if (n_old == 0) begin
                    c = lead_class(b);
                    if (c == 4) note_err(ubes_pkg::KIND_INVALID, b, x, 1);
                    else if (c != 0) begin
                        hold(b, x); n_needed = c;
                    end
                end else if (n == n_needed + 1) begin
                    cont_check(s, 0, n_needed, seq_start); n_held = 0;
                end else hold(b, x);
            end else if (mode == ubes_pkg::MODE_UTF16) begin
                bom = !wrapped && x < 2;
                if (!bom) begin
                    s[n] = b; n++;
                end
                if (fin) u16_tail(s, n, start);
                else if (!bom) begin
                    if (n == 2) begin
                        if (is_surr(u16(s, 0))) hold(b, x);
                        else n_held = 0;
                    end else if (n == 4) begin
                        pair_check(s, 0, seq_start); n_held = 0;
                    end else hold(b, x);
                end
            end else if (mode == ubes_pkg::MODE_UTF32) begin
                bom = !wrapped && x < 4;
                if (!bom) begin
                    s[n] = b; n++;
                end
                if (n == 4) begin
                    w = big_end ? {s[0], s[1], s[2], s[3]} : {s[3], s[2], s[1], s[0]};
                    if (w > 32'h0010ffff) note_err(ubes_pkg::KIND_ABOVE_MAX, w, start, 4);
                    n_held = 0;
                end else if (!bom && !fin) hold(b, x);
                if (fin && (x[1:0] + 2'd1) != 2'd0) note_err(ubes_pkg::KIND_LENGTH, b, x, 1);
            end
            pos = x + 1;
            if (pos == 0) wrapped = 1;
            if (fin) begin
                r = '0; r.error_total = err_cnt;
                run = {run, r};
                clear_stream();
            end
            if (run.size() > 0) run[run.size()-1].last_of_run = 1;
            foreach (run[k]) owed = {owed, run[k]};
        endfunction

        function void check_result(ubes_pkg::t_out got);
            ubes_pkg::t_out exp_r;
            if (owed.size() == 0) begin
                $error("record with nothing owed: %p", got);
                fails++;
                return;
            end
            exp_r = owed.pop_front();
            if (got.is_error != exp_r.is_error) begin
                $error("is_error exp %0d got %0d", exp_r.is_error, got.is_error); fails++;
            end
            if (got.error_kind != exp_r.error_kind) begin
                $error("error_kind exp %0d got %0d", exp_r.error_kind, got.error_kind);
                fails++;
            end
            if (got.bad_value != exp_r.bad_value) begin
                $error("bad_value exp %h got %h", exp_r.bad_value, got.bad_value); fails++;
            end
            if (got.first_position != exp_r.first_position) begin
                $error("first_position exp %0d got %0d", exp_r.first_position,
                       got.first_position);
                fails++;
            end
            if (got.position_count != exp_r.position_count) begin
                $error("position_count exp %0d got %0d", exp_r.position_count,
                       got.position_count);
                fails++;
            end
            if (got.error_total != exp_r.error_total) begin
                $error("error_total exp %0d got %0d", exp_r.error_total, got.error_total);
                fails++;
            end
            if (got.last_of_run != exp_r.last_of_run) begin
                $error("last_of_run exp %0d got %0d", exp_r.last_of_run, got.last_of_run);
                fails++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic           i_clk, i_rst_n;
    logic           push, full, empty, pop;
    ubes_pkg::t_in  i_in;
    ubes_pkg::t_out o_out;
    logic           i_cfg_valid, o_cfg_ready;
    logic [1:0]     i_cfg_index, i_cfg_data;

    int push_idle_pct, pop_idle_pct;
    int quiet_cycles;
    scan_scoreboard sb;

    unicode_byte_error_scanner_core dut (
        .i_clk, .i_rst_n, .push, .full, .i_in, .empty, .pop, .o_out,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random pop stalls, every accepted transaction scored
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) sb.check_result(o_out);
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // watchdog: cycles without any accepted transaction
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // one byte through the push side; sender gaps before the transaction;
    // push stays high afterwards until the next send, gap or drain
    task automatic send_byte(logic [7:0] b, logic fin);
        ubes_pkg::t_in it;
        it.data_byte = b; it.stream_end = fin;
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_in <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_input(it);
    endtask

    task automatic drain();
        push <= 0;
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only with the block idle
    task automatic write_reg(logic [1:0] idx, logic [1:0] val);
        drain();
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    // random stream; sequences shaped for the current mode, some damaged, mixed with random bytes
    task automatic random_stream(int len);
        int          k, c;
        logic [7:0]  b;
        logic [31:0] w;
        k = 0;
        while (k < len) begin
            if (sb.mode == ubes_pkg::MODE_UTF8 && $urandom_range(3) != 0) begin
                c = $urandom_range(3);
                case (c)
                    0: b = 8'($urandom_range(127));
                    1: b = 8'hc0 | 8'($urandom_range(31));
                    2: b = 8'he0 | 8'($urandom_range(15));
                    default: b = 8'hf0 | 8'($urandom_range(7));
                endcase
                send_byte(b, k == len - 1); k++;
                for (int j = 0; j < c && k < len; j++) begin
                    b = ($urandom_range(7) == 0) ? 8'($urandom)
                                                 : (8'h80 | 8'($urandom_range(63)));
                    send_byte(b, k == len - 1); k++;
                end
            end else if (sb.mode == ubes_pkg::MODE_UTF16 && $urandom_range(2) != 0) begin
                w = {16'hdc00 | 16'($urandom_range(16'h3ff)),
                     16'hd800 | 16'($urandom_range(16'h3ff))};
                if ($urandom_range(5) == 0) w[15:0] = 16'($urandom);
                if ($urandom_range(5) == 0) w[31:16] = 16'($urandom);
                for (int j = 0; j < 4 && k < len; j++) begin
                    b = sb.big_end ? w[8*(j^1) +: 8] : w[8*j +: 8];
                    send_byte(b, k == len - 1); k++;
                end
            end else if (sb.mode == ubes_pkg::MODE_UTF32 && $urandom_range(2) != 0) begin
                w = ($urandom_range(1)) ? $urandom_range(32'h10ffff) : $urandom;
                for (int j = 0; j < 4 && k < len; j++) begin
                    b = sb.big_end ? w[8*(3-j) +: 8] : w[8*j +: 8];
                    send_byte(b, k == len - 1); k++;
                end
            end else begin
                send_byte(8'($urandom), k == len - 1); k++;
            end
        end
    endtask

    task automatic random_phase(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(9) == 0) begin
                write_reg(ubes_pkg::REG_MODE, 2'($urandom_range(3)));
                write_reg(ubes_pkg::REG_ENDIAN, 2'($urandom_range(1)));
            end
            len = $urandom_range(1, 12);
            random_stream(len);
            sent += len;
        end
    endtask

    initial begin
        sb = new();
        sb.mode = ubes_pkg::MODE_UTF8; sb.big_end = 0; sb.fails = 0;
        sb.clear_stream();
        i_rst_n = 0; push = 0; pop = 0; i_in = '0;
        i_cfg_valid = 0; i_cfg_index = ubes_pkg::REG_MODE; i_cfg_data = '0;
        push_idle_pct = 9; pop_idle_pct = 46;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // UTF-8: ASCII byte, bad continuation, invalid lead, truncation at end
        send_byte(8'h00, 0); send_byte(8'hc3, 0); send_byte(8'h7f, 0);
        send_byte(8'hff, 0); send_byte(8'hf0, 0); send_byte(8'h9f, 1);
        send_byte(8'he2, 0); send_byte(8'hc0, 1);
        // UTF-16 big-endian: BOM, bad high and bad low, missing low, odd byte
        write_reg(ubes_pkg::REG_MODE, ubes_pkg::MODE_UTF16);
        write_reg(ubes_pkg::REG_ENDIAN, 1);
        send_byte(8'hfe, 0); send_byte(8'hff, 0);
        send_byte(8'hdc, 0); send_byte(8'h00, 0); send_byte(8'h00, 0);
        send_byte(8'h41, 0); send_byte(8'hd8, 0); send_byte(8'h00, 0);
        send_byte(8'h7a, 1);
        // UTF-32 little-endian: above max, length error in a short stream
        write_reg(ubes_pkg::REG_MODE, ubes_pkg::MODE_UTF32);
        write_reg(ubes_pkg::REG_ENDIAN, 0);
        send_byte(8'hff, 0); send_byte(8'hfe, 0); send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'hff, 0); send_byte(8'hff, 0); send_byte(8'hff, 0);
        send_byte(8'hff, 0); send_byte(8'h80, 1);
        send_byte(8'h01, 1);
        // unused mode: summary only
        write_reg(ubes_pkg::REG_MODE, ubes_pkg::MODE_NONE);
        send_byte(8'hff, 0); send_byte(8'hc0, 1);

        random_phase(150);
        push_idle_pct = 46; pop_idle_pct = 9;
        random_phase(150);
        push_idle_pct = 0; pop_idle_pct = 0;
        random_phase(150);

        drain();
        if (sb.fails == 0 && sb.owed.size() == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
